@@ rtl/buddy_page_allocator_assert.svh @@
// Assertion macros for the buddy page allocator.
// Included by modules that assert; no other dependencies.
`ifndef BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`define BUDDY_PAGE_ALLOCATOR_ASSERT_SVH
`ifndef SYNTH
`define BPA_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
`define BPA_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`else
`define BPA_ASSERT_IMP(label, clk, rst_n, a, c)
`define BPA_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

@@ rtl/bpa_pkg.sv @@
// Package for the buddy page allocator: item types, codes, commands.
// No dependencies.
package bpa_pkg;
  localparam int PAGE_COUNT_DEF = 256;
  localparam int MAX_ORDER_DEF  = 8;
  localparam int PAGE_BYTES_DEF = 4096;
  localparam int ORD_W = 4;
  localparam logic [3:0] ORDER_NONE = 4'hF;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOSPACE = 2'd1;
  localparam logic [1:0] ST_BADFREE = 2'd2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [31:0] request_bytes;
    logic [7:0]  block_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] result_index;
    logic [3:0] result_order;
  } out_item_t;

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_A_SCAN, S_A_RDNXT, S_A_POP, S_A_SPLIT,
    S_F_RD, S_F_CHK, S_F_BRD, S_F_BCHK, S_F_WALK, S_F_WCHK, S_F_UNLINK,
    S_F_PUSH, S_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_LOAD, OP_SCAN, OP_RD_HEAD, OP_POP,
    OP_SPLIT, OP_RD_IDX, OP_FREE_MARK, OP_RD_BUD, OP_MERGE_HEAD, OP_WALK_RD,
    OP_WALK_STEP, OP_UNLINK, OP_PUSH, OP_FAIL_NS, OP_FAIL_BF
  } op_t;

  typedef struct packed {
    logic clear_done;
    logic want_big;
    logic scan_hit;
    logic scan_end;
    logic split_done;
    logic free_bad;
    logic bud_ok;
    logic bud_is_head;
    logic walk_hit;
    logic walk_end;
  } stat_t;
endpackage

@@ rtl/bpa_ctrl.sv @@
// Controller state machine for the buddy page allocator.
// Depends on bpa_pkg.
module bpa_ctrl
  import bpa_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_fire,
  input  logic  in_cmd,
  input  logic  out_busy,
  input  stat_t st,
  output logic  in_ready,
  output op_t   op,
  output logic  done
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLEAR;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    op = OP_NONE;
    in_ready = 1'b0;
    done = 1'b0;
    case (state_r)
      S_CLEAR: begin
        op = OP_CLEAR;
        if (st.clear_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          op = OP_LOAD;
          state_nxt = (in_cmd == CMD_FREE) ? S_F_RD : S_A_SCAN;
        end
      end
      S_A_SCAN: begin
        if (st.want_big || st.scan_end) begin
          op = OP_FAIL_NS;
          state_nxt = S_DONE;
        end else if (st.scan_hit) begin
          op = OP_RD_HEAD;
          state_nxt = S_A_RDNXT;
        end else op = OP_SCAN;
      end
      S_A_RDNXT: state_nxt = S_A_POP;
      S_A_POP: begin
        op = OP_POP;
        state_nxt = S_A_SPLIT;
      end
      S_A_SPLIT: begin
        if (st.split_done) state_nxt = S_DONE;
        else op = OP_SPLIT;
      end
      S_F_RD: begin
        op = OP_RD_IDX;
        state_nxt = S_F_CHK;
      end
      S_F_CHK: begin
        if (st.free_bad) begin
          op = OP_FAIL_BF;
          state_nxt = S_DONE;
        end else begin
          op = OP_FREE_MARK;
          state_nxt = S_F_BRD;
        end
      end
      S_F_BRD: begin
        if (!st.bud_ok) state_nxt = S_F_PUSH;
        else begin
          op = OP_RD_BUD;
          state_nxt = S_F_BCHK;
        end
      end
      S_F_BCHK: begin
        if (!st.bud_ok) state_nxt = S_F_PUSH;
        else if (st.bud_is_head) begin
          op = OP_MERGE_HEAD;
          state_nxt = S_F_BRD;
        end else begin
          op = OP_WALK_RD;
          state_nxt = S_F_WCHK;
        end
      end
      S_F_WCHK: begin
        if (st.walk_hit) begin
          op = OP_UNLINK;
          state_nxt = S_F_BRD;
        end else if (st.walk_end) begin
          op = OP_UNLINK;
          state_nxt = S_F_BRD;
        end else begin
          op = OP_WALK_STEP;
          state_nxt = S_F_WALK;
        end
      end
      S_F_WALK: state_nxt = S_F_WCHK;
      S_F_UNLINK: state_nxt = S_F_BRD;
      S_F_PUSH: begin
        op = OP_PUSH;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_busy) begin
          done = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

@@ rtl/bpa_datapath.sv @@
// Datapath for the buddy page allocator: page tables, list heads, walk regs.
// Depends on bpa_pkg and buddy_page_allocator_assert.svh.
`include "buddy_page_allocator_assert.svh"
module bpa_datapath
  import bpa_pkg::*;
#(
  parameter int PAGE_COUNT = PAGE_COUNT_DEF,
  parameter int MAX_ORDER  = MAX_ORDER_DEF,
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  op_t       op,
  input  in_item_t  in_item,
  output stat_t     st,
  output out_item_t res
);
  localparam int PW = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
  localparam int LW = $clog2(PAGE_COUNT + 1);
  localparam logic [LW-1:0] LNULL = LW'(PAGE_COUNT);

  // order/alloc per page; link table as memory
  logic [ORD_W-1:0] ord_mem [PAGE_COUNT];
  logic             alloc_mem [PAGE_COUNT];
  logic [LW-1:0]    link_mem [PAGE_COUNT];
  logic [LW-1:0]    head_r [MAX_ORDER+1];

  logic [PW-1:0]    clr_r;
  logic [5:0]       want_r;
  logic             sized_r;
  logic [ORD_W:0]   lvl_r;
  logic [PW-1:0]    idx_r;
  logic [ORD_W-1:0] ord_r;
  logic [ORD_W-1:0] rd_ord_r;
  logic             rd_alloc_r;
  logic [LW-1:0]    rd_link_r;
  logic [LW-1:0]    bud_link_r;
  logic [LW-1:0]    cur_r;
  logic [LW-1:0]    bud_r;
  logic [PW:0]      steps_r;
  out_item_t        res_r;

  logic [PW:0]  bud_full;
  logic [LW-1:0] lvl_head;
  logic [PW:0] half_full;

  assign lvl_head = (lvl_r <= (ORD_W+1)'(MAX_ORDER)) ? head_r[lvl_r[ORD_W-1:0]] : LNULL;
  assign bud_full = {1'b0, idx_r} ^ ((PW+1)'(1) << ord_r);
  // split half for current level
  assign half_full = {1'b0, idx_r} + ((PW+1)'(1) << (lvl_r - 1'b1));

  always_comb begin
    st = '0;
    st.clear_done  = (clr_r == PW'(PAGE_COUNT - 1));
    st.want_big    = (want_r > 6'(MAX_ORDER));
    st.scan_end    = sized_r && (lvl_r > (ORD_W+1)'(MAX_ORDER));
    st.scan_hit    = sized_r && (lvl_head != LNULL);
    st.split_done  = ((ORD_W+1)'(want_r) == lvl_r);
    st.free_bad    = ({24'd0, in_item.block_index} >= 32'(PAGE_COUNT)) || !rd_alloc_r
                     || (rd_ord_r > ORD_W'(MAX_ORDER));
    st.bud_ok      = (ord_r < ORD_W'(MAX_ORDER)) && (bud_full < (PW+1)'(PAGE_COUNT))
                     && !rd_alloc_r && (rd_ord_r == ord_r);
    st.bud_is_head = (head_r[ord_r] == LW'(bud_full));
    st.walk_hit    = (rd_link_r == bud_r);
    st.walk_end    = (rd_link_r >= LNULL) || (steps_r >= (PW+1)'(PAGE_COUNT));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      sized_r <= 1'b0;
      for (int i = 0; i <= MAX_ORDER; i++) head_r[i] <= (i == MAX_ORDER) ? LW'(0) : LNULL;
    end else begin
      case (op)
        OP_CLEAR: begin
          clr_r <= clr_r + 1'b1;
          ord_mem[clr_r] <= (clr_r == '0) ? ORD_W'(MAX_ORDER) : ORDER_NONE;
          alloc_mem[clr_r] <= 1'b0;
          link_mem[clr_r] <= LNULL;
        end
        OP_LOAD: begin
          idx_r <= PW'(in_item.block_index);
          want_r <= '0;
          sized_r <= 1'b0;
          lvl_r <= '0;
          ord_r <= '0;
          rd_ord_r <= ord_mem[PW'(in_item.block_index)];
          rd_alloc_r <= alloc_mem[PW'(in_item.block_index)];
        end
        OP_SCAN: begin
          if (!sized_r) begin
            // smallest order whose block holds the bytes, one order a cycle
            if (64'(in_item.request_bytes) > (64'(PAGE_BYTES) << want_r))
              want_r <= want_r + 1'b1;
            else begin
              sized_r <= 1'b1;
              lvl_r <= (ORD_W+1)'(want_r);
            end
          end else lvl_r <= lvl_r + 1'b1;
        end
        OP_RD_HEAD: begin
          idx_r <= PW'(lvl_head);
          rd_link_r <= link_mem[PW'(lvl_head)];
        end
        OP_POP: begin
          head_r[lvl_r[ORD_W-1:0]] <= rd_link_r;
          link_mem[idx_r] <= LNULL;
          ord_mem[idx_r] <= ORD_W'(want_r);
          alloc_mem[idx_r] <= 1'b1;
          res_r <= '{ST_OK, 8'(idx_r), ORD_W'(want_r)};
        end
        OP_SPLIT: begin
          if (half_full < (PW+1)'(PAGE_COUNT)) begin
            ord_mem[PW'(half_full)] <= ORD_W'(lvl_r - 1'b1);
            alloc_mem[PW'(half_full)] <= 1'b0;
            link_mem[PW'(half_full)] <= head_r[lvl_r[ORD_W-1:0] - 1'b1];
            head_r[lvl_r[ORD_W-1:0] - 1'b1] <= LW'(half_full);
          end
          lvl_r <= lvl_r - 1'b1;
        end
        OP_FREE_MARK: begin
          ord_r <= rd_ord_r;
          alloc_mem[idx_r] <= 1'b0;
          ord_mem[idx_r] <= ORDER_NONE;
          rd_ord_r <= rd_ord_r;
          rd_alloc_r <= 1'b0;
        end
        OP_RD_BUD: begin
          bud_r <= LW'(bud_full);
          rd_ord_r <= ord_mem[PW'(bud_full)];
          rd_alloc_r <= alloc_mem[PW'(bud_full)];
          rd_link_r <= link_mem[PW'(bud_full)];
          bud_link_r <= link_mem[PW'(bud_full)];
        end
        OP_MERGE_HEAD: begin
          head_r[ord_r] <= rd_link_r;
          link_mem[PW'(bud_r)] <= LNULL;
          ord_mem[PW'(bud_r)] <= ORDER_NONE;
          ord_r <= ord_r + 1'b1;
          if (PW'(bud_r) < idx_r) idx_r <= PW'(bud_r);
          rd_ord_r <= ord_r + 1'b1;
          rd_alloc_r <= 1'b0;
        end
        OP_WALK_RD: begin
          cur_r <= head_r[ord_r];
          rd_link_r <= link_mem[PW'(head_r[ord_r])];
          steps_r <= '0;
        end
        OP_WALK_STEP: begin
          cur_r <= rd_link_r;
          rd_link_r <= link_mem[PW'(rd_link_r)];
          steps_r <= steps_r + 1'b1;
        end
        OP_UNLINK: begin
          // the buddy's own link is rewritten whenever it is pushed again
          if (st.walk_hit) link_mem[PW'(cur_r)] <= bud_link_r;
          ord_mem[PW'(bud_r)] <= ORDER_NONE;
          ord_r <= ord_r + 1'b1;
          if (PW'(bud_r) < idx_r) idx_r <= PW'(bud_r);
          rd_ord_r <= ord_r + 1'b1;
          rd_alloc_r <= 1'b0;
        end
        OP_PUSH: begin
          ord_mem[idx_r] <= ord_r;
          link_mem[idx_r] <= head_r[ord_r];
          head_r[ord_r] <= LW'(idx_r);
          res_r <= '{ST_OK, 8'(idx_r), ord_r};
        end
        OP_FAIL_NS: res_r <= '{ST_NOSPACE, 8'd0, 4'd0};
        OP_FAIL_BF: res_r <= '{ST_BADFREE, 8'd0, 4'd0};
        default: ;
      endcase
    end
  end

  assign res = res_r;

  `BPA_ASSERT_IMP(a_push_ok, clk, rst_n, op == OP_PUSH, ord_r <= ORD_W'(MAX_ORDER))
  `BPA_ASSERT_NXT(a_merge_up, clk, rst_n, op == OP_MERGE_HEAD, ord_r == $past(ord_r) + 1'b1)
  `BPA_ASSERT_IMP(a_walk_bound, clk, rst_n, op == OP_WALK_STEP, steps_r < (PW+1)'(PAGE_COUNT))
endmodule

@@ rtl/buddy_page_allocator.sv @@
// Top level of the buddy page allocator: handshake, output register.
// Depends on bpa_pkg, bpa_ctrl and bpa_datapath.
//
//  channel | direction | payload
//  in_     | input     | in_item_t  (cmd, request_bytes, block_index)
//  out_    | output    | out_item_t (status, result_index, result_order)
//
// One item at a time. Allocate: sizing tries one order at a time, then the list
// levels are scanned upward, the head block is read and popped, it is split down
// one level per step, and the result is handed off.
// Free: the block is read and checked, then each merge reads and checks the buddy,
// walking its list when the buddy is not at the head, and the merged block is pushed.
// After reset a clearing pass over all pages runs before in_ready.
// A result waits in the output register while the next item is accepted;
// the next result stalls until it is taken.
module buddy_page_allocator
  import bpa_pkg::*;
#(
  parameter int PAGE_COUNT = PAGE_COUNT_DEF,
  parameter int MAX_ORDER  = MAX_ORDER_DEF,
  parameter int PAGE_BYTES = PAGE_BYTES_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);
  op_t       op;
  stat_t     st;
  logic      done;
  logic      out_valid_r;
  out_item_t out_r;
  out_item_t res;
  in_item_t  in_r;
  logic      rdy;

  assign in_ready = rdy;

  always_ff @(posedge clk) begin
    if (in_valid && rdy) in_r <= in_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (done) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (done) out_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  bpa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_valid && rdy), .in_cmd(in_data.cmd),
    .out_busy(out_valid_r && !out_ready), .st(st), .in_ready(rdy), .op(op),
    .done(done)
  );

  bpa_datapath #(
    .PAGE_COUNT(PAGE_COUNT), .MAX_ORDER(MAX_ORDER), .PAGE_BYTES(PAGE_BYTES)
  ) u_dp (
    .clk(clk), .rst_n(rst_n), .op(op),
    .in_item((op == OP_LOAD) ? in_data : in_r), .st(st), .res(res)
  );
endmodule

@@ sim/buddy_page_allocator_tb.sv @@
// Testbench for buddy_page_allocator: directed and random allocate/free items,
// checked against an in-bench buddy allocator predictor. Depends on bpa_pkg.
`timescale 1ns / 1ps
module buddy_page_allocator_tb
  import bpa_pkg::*;
;

  localparam int NPAGES = PAGE_COUNT_DEF;
  localparam int TOP_ORD = MAX_ORDER_DEF;
  localparam int PBYTES = PAGE_BYTES_DEF;
  localparam int NIL = NPAGES;
  localparam int NO_ORD = 255;
  localparam int WATCHDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;

  buddy_page_allocator u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  int pg_ord[NPAGES];
  bit pg_alloc[NPAGES];
  int pg_next[NPAGES];
  int list_head[TOP_ORD+1];
  out_item_t expected_results[$];
  int held_blocks[$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  int n_alloc_ok = 0;
  int n_merges = 0;
  bit send_gaps = 1'b1;
  bit recv_gaps = 1'b1;
  int recv_hold_cycles = 0;
  int recv_wait = 0;
  int idle_cycles = 0;

  function automatic void pool_reset();
    for (int i = 0; i < NPAGES; i++) begin
      pg_ord[i] = NO_ORD;
      pg_alloc[i] = 1'b0;
      pg_next[i] = NIL;
    end
    for (int i = 0; i <= TOP_ORD; i++) list_head[i] = NIL;
    pg_ord[0] = TOP_ORD;
    list_head[TOP_ORD] = 0;
  endfunction

  function automatic void list_unlink(int ord, int page);
    int cur;
    int steps;
    cur = list_head[ord];
    steps = 0;
    if (cur == page) begin
      list_head[ord] = pg_next[page];
      pg_next[page] = NIL;
      return;
    end
    while (cur < NPAGES && steps < NPAGES) begin
      if (pg_next[cur] == page) begin
        pg_next[cur] = pg_next[page];
        pg_next[page] = NIL;
        return;
      end
      cur = pg_next[cur];
      steps++;
    end
  endfunction

  function automatic out_item_t predict_alloc(logic [31:0] bytes);
    out_item_t r;
    longint unsigned pages;
    int want;
    int head;
    int half;
    r = '0;
    r.status = ST_NOSPACE;
    pages = (longint'(bytes) + PBYTES - 1) / PBYTES;
    if (pages == 0) pages = 1;
    want = 0;
    while (want < 40 && (64'd1 << want) < pages) want++;
    if (want > TOP_ORD) return r;
    for (int lvl = want; lvl <= TOP_ORD; lvl++) begin
      head = list_head[lvl];
      if (head >= NPAGES) continue;
      list_head[lvl] = pg_next[head];
      pg_next[head] = NIL;
      pg_ord[head] = want;
      pg_alloc[head] = 1'b1;
      for (int j = lvl; j > want; j--) begin
        half = head + (1 << (j - 1));
        if (half >= NPAGES) continue;
        pg_ord[half] = j - 1;
        pg_alloc[half] = 1'b0;
        pg_next[half] = list_head[j-1];
        list_head[j-1] = half;
      end
      r.status = ST_OK;
      r.result_index = head[7:0];
      r.result_order = want[3:0];
      held_blocks.push_back(head);
      n_alloc_ok++;
      return r;
    end
    return r;
  endfunction

  function automatic out_item_t predict_free(int idx);
    out_item_t r;
    int ord;
    int bud;
    r = '0;
    if (idx >= NPAGES || !pg_alloc[idx] || pg_ord[idx] == NO_ORD || pg_ord[idx] > TOP_ORD) begin
      r.status = ST_BADFREE;
      return r;
    end
    ord = pg_ord[idx];
    pg_alloc[idx] = 1'b0;
    pg_ord[idx] = NO_ORD;
    while (ord < TOP_ORD) begin
      bud = idx ^ (1 << ord);
      if (bud >= NPAGES || pg_alloc[bud] || pg_ord[bud] != ord) break;
      list_unlink(ord, bud);
      pg_ord[bud] = NO_ORD;
      ord++;
      n_merges++;
      if (bud < idx) idx = bud;
    end
    pg_ord[idx] = ord;
    pg_next[idx] = list_head[ord];
    list_head[ord] = idx;
    r.status = ST_OK;
    r.result_index = idx[7:0];
    r.result_order = ord[3:0];
    return r;
  endfunction

  // valid stays high between items sent back to back; stop_input drops it
  task automatic send_item(in_item_t it);
    if (send_gaps && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    if (it.cmd == CMD_ALLOC) expected_results.push_back(predict_alloc(it.request_bytes));
    else begin
      for (int i = 0; i < held_blocks.size(); i++)
        if (held_blocks[i] == int'(it.block_index)) begin
          held_blocks.delete(i);
          break;
        end
      expected_results.push_back(predict_free(int'(it.block_index)));
    end
    n_items++;
    @(negedge clk);
  endtask

  task automatic stop_input();
    in_valid <= 1'b0;
  endtask

  task automatic send_alloc(logic [31:0] bytes);
    in_item_t it;
    it = '0;
    it.cmd = CMD_ALLOC;
    it.request_bytes = bytes;
    it.block_index = 8'($urandom());
    send_item(it);
  endtask

  task automatic send_free(logic [7:0] idx);
    in_item_t it;
    it = '0;
    it.cmd = CMD_FREE;
    it.block_index = idx;
    it.request_bytes = $urandom();
    send_item(it);
  endtask

  task automatic wait_drained();
    stop_input();
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // receiver
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if (recv_hold_cycles != 0) begin
      out_ready <= 1'b0;
      recv_hold_cycles--;
    end else if (recv_wait != 0) begin
      out_ready <= 1'b0;
      recv_wait--;
    end else if (recv_gaps && $urandom_range(0, 5) == 0) begin
      out_ready <= 1'b0;
      recv_wait = $urandom_range(1, 17) - 1;
    end else out_ready <= 1'b1;
  end

  // result checker and watchdog
  always @(posedge clk) begin
    out_item_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (out_data.status !== exp_r.status)
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, out_data.status);
        if (out_data.result_index !== exp_r.result_index)
          $display("%0t: index expected %0d actual %0d", $time, exp_r.result_index,
                   out_data.result_index);
        if (out_data.result_order !== exp_r.result_order)
          $display("%0t: order expected %0d actual %0d", $time, exp_r.result_order,
                   out_data.result_order);
        if (out_data !== exp_r) errors++;
      end
    end
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("buddy_page_allocator test failed");
      $finish;
    end
  end

  task automatic test_directed();
    send_alloc(32'd0);
    send_alloc(32'd1);
    send_alloc(32'd4096);
    send_alloc(32'd4097);
    send_alloc(32'hFFFF_FFFF);
    send_alloc(32'd1048577);
    send_free(8'd0);
    send_free(8'd255);
    send_free(8'd1);
    send_free(8'd0);
    send_free(8'd2);
    send_free(8'd4);
    send_alloc(32'd1048576);
    send_alloc(32'd1);
    send_free(8'd0);
    send_free(8'd0);
    send_alloc(32'h8000_0000);
    send_alloc(32'd524288);
    send_alloc(32'd524288);
    send_free(8'd128);
    send_free(8'd0);
    wait_drained();
  endtask

  task automatic test_backpressure();
    recv_hold_cycles = 300;
    for (int i = 0; i < 6; i++) send_alloc($urandom_range(0, 20000));
    wait_drained();
  endtask

  task automatic test_random(int count);
    int k;
    int pick;
    for (int i = 0; i < count; i++) begin
      if (i == count - 60) begin
        send_gaps = 1'b0;
        recv_gaps = 1'b0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        case ($urandom_range(0, 3))
          0: send_alloc($urandom_range(0, 4 * PBYTES));
          1: send_alloc($urandom_range(0, 64 * PBYTES));
          2: send_alloc($urandom_range(0, NPAGES * PBYTES + 100));
          default: send_alloc($urandom());
        endcase
      end else if (pick < 85 && held_blocks.size() != 0) begin
        k = $urandom_range(0, held_blocks.size() - 1);
        send_free(8'(held_blocks[k]));
      end else send_free(8'($urandom()));
    end
    stop_input();
  endtask

  initial begin
    pool_reset();
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_backpressure();
    test_random(470);
    wait_drained();
    repeat (200) @(negedge clk);
    $display("Covered %0d items, %0d results, %0d successful allocations, %0d merges.",
             n_items, n_results, n_alloc_ok, n_merges);
    if (errors == 0 && expected_results.size() == 0)
      $display("buddy_page_allocator test passed");
    else
      $display("buddy_page_allocator test failed");
    $finish;
  end
endmodule
